FILE: sv/caps_pkg.sv
// ----------------------------------------------------------------------------
// caps_pkg - shared types and constants of the circular arc point sampler
// Field widths, fixed-point constants, CORDIC arctangent table, FSM states.
// ----------------------------------------------------------------------------
package caps_pkg;

  // CORDIC iteration count and saturation width of centers and points
  localparam int CORDIC_STAGES = 16;
  localparam int COORD_WIDTH   = 32;

  // channel field widths
  localparam int OFS_W  = 24;
  localparam int FRAC_W = 17;
  localparam int DATA_W = 32;
  localparam int IDX_W  = 3;
  localparam int ANG_W  = 20;

  // serial multiplier operand and product widths
  localparam int OP_W   = 34;
  localparam int PROD_W = 2 * OP_W;

  // angle constants, Q3.16 radians
  localparam logic signed [20:0] PI_Q16      = 21'sd205887;
  localparam logic signed [20:0] HALF_PI_Q16 = 21'sd102944;
  localparam logic signed [20:0] TWO_PI_Q16  = 21'sd411775;

  // CORDIC start value in Q2.30 and Q16 to Q30 angle shift
  localparam logic signed [OP_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam int Z_SHIFT = 14;

  // largest arc position
  localparam logic [30:0] POS_MAX = 31'h7FFF_FFFF;

  // arctangent of 2^-i in Q2.30
  localparam logic [29:0] ATAN_Q30 [32] = '{
    30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159,
    30'd67021687,  30'd33543516,  30'd16775851,  30'd8388437,
    30'd4194283,   30'd2097149,   30'd1048576,   30'd524288,
    30'd262144,    30'd131072,    30'd65536,     30'd32768,
    30'd16384,     30'd8192,      30'd4096,      30'd2048,
    30'd1024,      30'd512,       30'd256,       30'd128,
    30'd64,        30'd32,        30'd16,        30'd8,
    30'd4,         30'd2,         30'd1,         30'd1
  };

  // action codes
  localparam logic ACT_START = 1'b0;

  // configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_REAR_POS_X     = 3'd0,
    REG_REAR_POS_Y     = 3'd1,
    REG_REAR_HEADING   = 3'd2,
    REG_REAR_PATH_DIST = 3'd3,
    REG_ARC_RADIUS     = 3'd4,
    REG_ARC_ANGLE      = 3'd5,
    REG_LANE_WIDTH     = 3'd6,
    REG_END_TOL        = 3'd7
  } cfg_reg_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE, S_LEN, S_OFF, S_DIV, S_TH, S_MOD, S_FOLD,
    S_CORDIC, S_CX, S_CY, S_PX, S_PY, S_OUT
  } state_t;

  // status of an iterative unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

FILE: sv/caps_if.sv
// ----------------------------------------------------------------------------
// caps_if - channel interfaces of the circular arc point sampler
// Input item, result item and configuration write channels.
// ----------------------------------------------------------------------------
interface caps_in_if import caps_pkg::*;;
  logic              valid;
  logic              ready;
  logic              action;
  logic [OFS_W-1:0]  start_offset;
  logic [OFS_W-1:0]  step_length;
  logic [FRAC_W-1:0] lateral_fraction;

  modport source (output valid, action, start_offset, step_length,
                  lateral_fraction, input ready);
  modport sink   (input valid, action, start_offset, step_length,
                  lateral_fraction, output ready);
endinterface

interface caps_out_if import caps_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] path_pos;
  logic signed [DATA_W-1:0] point_x;
  logic signed [DATA_W-1:0] point_y;
  logic                     at_end;
  logic signed [DATA_W-1:0] overshoot;

  modport source (output valid, path_pos, point_x, point_y, at_end, overshoot,
                  input ready);
  modport sink   (input valid, path_pos, point_x, point_y, at_end, overshoot,
                  output ready);
endinterface

interface caps_cfg_if import caps_pkg::*;;
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  index;
  logic [DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/caps_mul.sv
// ----------------------------------------------------------------------------
// caps_mul - bit-serial signed multiplier
// Shift-add on operand magnitudes, one multiplier bit per cycle, sign applied
// in a final cycle. Product is valid while stat.done is high.
// ----------------------------------------------------------------------------
module caps_mul import caps_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [OP_W-1:0]   a,
  input  logic signed [OP_W-1:0]   b,
  output unit_stat_t               stat,
  output logic signed [PROD_W-1:0] p
);

  localparam int CNT_W = $clog2(OP_W + 1);

  logic [OP_W-1:0]   mc_r, hi_r, lo_r;
  logic              neg_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r, fin_r, done_r;
  logic signed [PROD_W-1:0] p_r;
  logic [OP_W:0]     sum;
  logic [PROD_W-1:0] prod;

  // one partial product per cycle
  always_comb begin
    sum  = {1'b0, hi_r} + (lo_r[0] ? {1'b0, mc_r} : '0);
    prod = {hi_r, lo_r};
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= fin_r;
      fin_r  <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(OP_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      mc_r  <= a[OP_W-1] ? OP_W'(-a) : a;
      lo_r  <= b[OP_W-1] ? OP_W'(-b) : b;
      hi_r  <= '0;
      neg_r <= a[OP_W-1] ^ b[OP_W-1];
    end else if (busy_r) begin
      hi_r <= sum[OP_W:1];
      lo_r <= {sum[0], lo_r[OP_W-1:1]};
    end
    if (fin_r) begin
      p_r <= neg_r ? -$signed(prod) : $signed(prod);
    end
  end

  assign stat.busy = busy_r | fin_r;
  assign stat.done = done_r;
  assign p         = p_r;

endmodule

FILE: sv/caps_cordic.sv
// ----------------------------------------------------------------------------
// caps_cordic - iterative CORDIC rotation
// One micro-rotation per cycle on Q2.30 values; the angle comes in already
// folded into +-pi/2 with a flag that negates both results.
// ----------------------------------------------------------------------------
module caps_cordic import caps_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic signed [ANG_W-1:0] ang,
  input  logic                   neg,
  output unit_stat_t             stat,
  output logic signed [OP_W-1:0] cs,
  output logic signed [OP_W-1:0] sn
);

  localparam int IT_W = $clog2(CORDIC_STAGES + 1);

  logic signed [OP_W-1:0] x_r, y_r, z_r, cs_r, sn_r;
  logic signed [OP_W-1:0] dx, dy, at;
  logic [IT_W-1:0]        i_r;
  logic                   neg_r, busy_r, fin_r, done_r;

  // shifted terms and table angle of this iteration
  always_comb begin
    dx = y_r >>> i_r;
    dy = x_r >>> i_r;
    at = $signed({{(OP_W-30){1'b0}}, ATAN_Q30[5'(i_r)]});
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      i_r    <= '0;
    end else begin
      done_r <= fin_r;
      fin_r  <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        i_r    <= '0;
      end else if (busy_r) begin
        i_r <= i_r + 1'b1;
        if (i_r == IT_W'(CORDIC_STAGES - 1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end
    end
  end

  // rotation datapath
  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= CORDIC_GAIN;
      y_r   <= '0;
      z_r   <= OP_W'(ang) <<< Z_SHIFT;
      neg_r <= neg;
    end else if (busy_r) begin
      if (!z_r[OP_W-1]) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + at;
      end
    end
    if (fin_r) begin
      cs_r <= neg_r ? -x_r : x_r;
      sn_r <= neg_r ? -y_r : y_r;
    end
  end

  assign stat.busy = busy_r | fin_r;
  assign stat.done = done_r;
  assign cs        = cs_r;
  assign sn        = sn_r;

endmodule

FILE: sv/circular_arc_point_sampler_top.sv
// ----------------------------------------------------------------------------
// circular_arc_point_sampler_top - samples points along a lane-offset arc
// Sequencer around a bit-serial multiplier, a bit-serial divider, a serial
// angle reducer and an iterative CORDIC.
// ----------------------------------------------------------------------------
// Channels: in_ch takes one beat per item (action 0 starts a pass, action 1
// asks for the next point), out_ch gives one result beat per next item and
// none for a start item, cfg_ch writes the eight registers by index.
// cfg_ch is always ready; registers are to be written only while the block
// is idle, which the block itself does not enforce. A start item runs four
// multiplies, an angle reduction and a CORDIC. A next item runs a divide,
// the reduction, the CORDIC and two multiplies. A next item past the arc end
// skips the arithmetic and goes straight to the output step.
// Throughput: one item at a time; in_ch.ready is high only in idle, and
// the bit-serial divider and reducer take one bit per cycle.
// Results sit in an output register, so a new item is taken while a result
// waits; when out_ch stalls, a finished point holds the block until taken.
// Reset: synchronous, active low; configuration and pass registers, state and
// out_ch.valid return to zero, the radius to 1.0; no clearing pass is needed.
// ----------------------------------------------------------------------------
module circular_arc_point_sampler_top import caps_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  caps_in_if.sink    in_ch,
  caps_out_if.source out_ch,
  caps_cfg_if.sink   cfg_ch
);

  localparam int DIV_STEPS = 47;
  localparam int MOD_STEPS = 48;
  localparam int SUM_W     = (COORD_WIDTH > 39 ? COORD_WIDTH : 39) + 1;
  localparam logic signed [SUM_W-1:0] CMAX =
    {{(SUM_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] CMIN = ~CMAX;

  // configuration registers
  logic signed [31:0] rear_pos_x_r, rear_pos_y_r, rear_path_distance_r;
  logic signed [19:0] rear_heading_r, arc_angle_r;
  logic [30:0]        arc_radius_r;
  logic [23:0]        lane_width_r;
  logic [15:0]        end_tolerance_r;

  // pass state
  logic [30:0]                   arc_pos_r, arc_length_r;
  logic [23:0]                   step_size_r;
  logic signed [31:0]            offset_radius_r;
  logic signed [COORD_WIDTH-1:0] center_x_r, center_y_r;

  // sequencer
  state_t state_r, state_nxt;
  logic   launch_r, launch_nxt;
  logic   mode_r;

  // work registers
  logic signed [17:0] frac_r;
  logic signed [48:0] th_r;
  logic [5:0]         cnt_r;
  logic [30:0]        rem_r;
  logic [46:0]        quo_r;
  logic [47:0]        mag_r;
  logic [18:0]        mrem_r;
  logic               mneg_r;
  logic signed [ANG_W-1:0] ang_t_r;
  logic               ang_neg_r;

  // result staging and output register
  logic signed [31:0] res_path_r, res_px_r, res_py_r, res_over_r;
  logic               res_end_r;
  logic               out_valid_r;
  logic signed [31:0] out_path_r, out_px_r, out_py_r, out_over_r;
  logic               out_end_r;

  // units
  unit_stat_t               mul_st, cor_st;
  logic                     mul_start, cor_start;
  logic signed [OP_W-1:0]   mul_a, mul_b, cs, sn;
  logic signed [PROD_W-1:0] mul_p;

  // combinational helpers
  logic               in_acc, sg_neg, end_hit, out_go;
  logic [19:0]        abs_ang;
  logic [30:0]        dvs;
  logic [31:0]        dtrial;
  logic               dge;
  logic [19:0]        mtrial;
  logic               mge;
  logic [35:0]        len_w;
  logic signed [34:0] term;
  logic signed [35:0] orad_w;
  logic signed [38:0] mq;
  logic signed [SUM_W-1:0] cx_w, cy_w, px_w, py_w;
  logic signed [32:0] path_w;
  logic [31:0]        np_w;
  logic signed [48:0] psi49, q49;
  logic signed [20:0] t0, t1, t2;
  logic               fneg;

  function automatic logic signed [COORD_WIDTH-1:0] sat_coord(
    input logic signed [SUM_W-1:0] v);
    if (v > CMAX)      sat_coord = CMAX[COORD_WIDTH-1:0];
    else if (v < CMIN) sat_coord = CMIN[COORD_WIDTH-1:0];
    else               sat_coord = v[COORD_WIDTH-1:0];
  endfunction

  // ---------------------------------------------------------------- config
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rear_pos_x_r         <= '0;
      rear_pos_y_r         <= '0;
      rear_heading_r       <= '0;
      rear_path_distance_r <= '0;
      arc_radius_r         <= 31'd65536;
      arc_angle_r          <= '0;
      lane_width_r         <= '0;
      end_tolerance_r      <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_reg_t'(cfg_ch.index))
        REG_REAR_POS_X:     rear_pos_x_r         <= cfg_ch.data;
        REG_REAR_POS_Y:     rear_pos_y_r         <= cfg_ch.data;
        REG_REAR_HEADING:   rear_heading_r       <= cfg_ch.data[19:0];
        REG_REAR_PATH_DIST: rear_path_distance_r <= cfg_ch.data;
        REG_ARC_RADIUS:     arc_radius_r         <= cfg_ch.data[30:0];
        REG_ARC_ANGLE:      arc_angle_r          <= cfg_ch.data[19:0];
        REG_LANE_WIDTH:     lane_width_r         <= cfg_ch.data[23:0];
        REG_END_TOL:        end_tolerance_r      <= cfg_ch.data[15:0];
      endcase
    end
  end

  // ---------------------------------------------------------------- units
  caps_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .stat  (mul_st),
    .p     (mul_p)
  );

  caps_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cor_start),
    .ang   (ang_t_r),
    .neg   (ang_neg_r),
    .stat  (cor_st),
    .cs    (cs),
    .sn    (sn)
  );

  assign mul_start = launch_r && (state_r == S_LEN || state_r == S_OFF ||
                                  state_r == S_CX  || state_r == S_CY  ||
                                  state_r == S_PX  || state_r == S_PY);
  assign cor_start = launch_r && (state_r == S_CORDIC);

  // multiplier operands per step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_LEN: begin
        mul_a = $signed({{(OP_W-20){1'b0}}, abs_ang});
        mul_b = $signed({{(OP_W-31){1'b0}}, arc_radius_r});
      end
      S_OFF: begin
        mul_a = OP_W'(frac_r);
        mul_b = $signed({{(OP_W-24){1'b0}}, lane_width_r});
      end
      S_CX, S_CY: begin
        mul_a = $signed({{(OP_W-31){1'b0}}, arc_radius_r});
        mul_b = (state_r == S_CX) ? sn : cs;
      end
      S_PX, S_PY: begin
        mul_a = OP_W'(offset_radius_r);
        mul_b = (state_r == S_PX) ? cs : sn;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- arithmetic
  always_comb begin
    in_acc  = in_ch.valid & in_ch.ready;
    sg_neg  = arc_angle_r[19];
    abs_ang = sg_neg ? 20'(-arc_angle_r) : arc_angle_r;
    end_hit = ({1'b0, arc_pos_r} > ({1'b0, arc_length_r} + 32'(end_tolerance_r)))
              || (arc_pos_r == POS_MAX);
    out_go  = !out_valid_r || out_ch.ready;

    // divider step
    dvs    = (arc_radius_r == '0) ? 31'd1 : arc_radius_r;
    dtrial = {rem_r, quo_r[46]};
    dge    = dtrial >= {1'b0, dvs};

    // angle reduction step
    mtrial = {mrem_r, mag_r[47]};
    mge    = mtrial >= 20'(TWO_PI_Q16);

    // arc length and offset radius, rounded half up at bit 16
    len_w  = mul_p[51:16] + 36'(mul_p[15]);
    term   = $signed({mul_p[49], mul_p[49:16]}) + $signed({34'd0, mul_p[15]});
    orad_w = sg_neg ? $signed({5'd0, arc_radius_r}) + 36'(term)
                    : $signed({5'd0, arc_radius_r}) - 36'(term);

    // Q30 product rounded half up
    mq   = $signed({mul_p[67], mul_p[67:30]}) + $signed({38'd0, mul_p[29]});
    cx_w = sg_neg ? SUM_W'(rear_pos_x_r) + SUM_W'(mq) : SUM_W'(rear_pos_x_r) - SUM_W'(mq);
    cy_w = sg_neg ? SUM_W'(rear_pos_y_r) - SUM_W'(mq) : SUM_W'(rear_pos_y_r) + SUM_W'(mq);
    px_w = sg_neg ? SUM_W'(center_x_r) - SUM_W'(mq) : SUM_W'(center_x_r) + SUM_W'(mq);
    py_w = sg_neg ? SUM_W'(center_y_r) - SUM_W'(mq) : SUM_W'(center_y_r) + SUM_W'(mq);

    // path distance and next position
    path_w = 33'(rear_path_distance_r) + $signed({2'b0, arc_pos_r});
    np_w   = {1'b0, arc_pos_r} + 32'(step_size_r);

    // point angle before reduction
    psi49 = 49'(rear_heading_r);
    q49   = $signed({2'b0, quo_r});

    // fold reduced angle into +-pi/2
    t0 = (mneg_r && mrem_r != '0) ? TWO_PI_Q16 - $signed({2'b0, mrem_r})
                                  : $signed({2'b0, mrem_r});
    t1 = (t0 > PI_Q16) ? t0 - TWO_PI_Q16 : t0;
    if (t1 > HALF_PI_Q16) begin
      t2   = t1 - PI_Q16;
      fneg = 1'b1;
    end else if (t1 < -HALF_PI_Q16) begin
      t2   = t1 + PI_Q16;
      fneg = 1'b1;
    end else begin
      t2   = t1;
      fneg = 1'b0;
    end
  end

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt  = state_r;
    launch_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_ch.action == ACT_START) begin
            state_nxt  = S_LEN;
            launch_nxt = 1'b1;
          end else if (end_hit) begin
            state_nxt = S_OUT;
          end else begin
            state_nxt  = S_DIV;
            launch_nxt = 1'b1;
          end
        end
      end
      S_LEN: begin
        if (mul_st.done) begin
          state_nxt  = S_OFF;
          launch_nxt = 1'b1;
        end
      end
      S_OFF: begin
        if (mul_st.done) begin
          state_nxt  = S_MOD;
          launch_nxt = 1'b1;
        end
      end
      S_DIV: begin
        if (!launch_r && cnt_r == 6'd1) state_nxt = S_TH;
      end
      S_TH: begin
        state_nxt  = S_MOD;
        launch_nxt = 1'b1;
      end
      S_MOD: begin
        if (!launch_r && cnt_r == 6'd1) state_nxt = S_FOLD;
      end
      S_FOLD: begin
        state_nxt  = S_CORDIC;
        launch_nxt = 1'b1;
      end
      S_CORDIC: begin
        if (cor_st.done) begin
          state_nxt  = (mode_r == ACT_START) ? S_CX : S_PX;
          launch_nxt = 1'b1;
        end
      end
      S_CX: begin
        if (mul_st.done) begin
          state_nxt  = S_CY;
          launch_nxt = 1'b1;
        end
      end
      S_CY: begin
        if (mul_st.done) state_nxt = S_IDLE;
      end
      S_PX: begin
        if (mul_st.done) begin
          state_nxt  = S_PY;
          launch_nxt = 1'b1;
        end
      end
      S_PY: begin
        if (mul_st.done) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_go) state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_ch.ready = (state_r == S_IDLE);

  // control and pass state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      launch_r        <= 1'b0;
      out_valid_r     <= 1'b0;
      arc_pos_r       <= '0;
      step_size_r     <= '0;
      offset_radius_r <= '0;
      center_x_r      <= '0;
      center_y_r      <= '0;
      arc_length_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      launch_r <= launch_nxt;

      // output register
      if (state_r == S_OUT && out_go) out_valid_r <= 1'b1;
      else if (out_ch.ready)          out_valid_r <= 1'b0;

      // start of a pass
      if (in_acc && in_ch.action == ACT_START) begin
        arc_pos_r   <= 31'(in_ch.start_offset);
        step_size_r <= in_ch.step_length;
      end

      if (mul_st.done) begin
        case (state_r)
          S_LEN: arc_length_r <= (len_w > 36'(POS_MAX)) ? POS_MAX : len_w[30:0];
          S_OFF: begin
            if (orad_w > 36'sh07FFFFFFF)       offset_radius_r <= 32'sh7FFFFFFF;
            else if (orad_w < -36'sh080000000) offset_radius_r <= 32'sh80000000;
            else                               offset_radius_r <= orad_w[31:0];
          end
          S_CX: center_x_r <= sat_coord(cx_w);
          S_CY: center_y_r <= sat_coord(cy_w);
          S_PY: arc_pos_r  <= np_w[31] ? POS_MAX : np_w[30:0];
          default: ;
        endcase
      end
    end
  end

  // work datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r <= in_ch.action;
      frac_r <= $signed({1'b0, in_ch.lateral_fraction}) - 18'sd32768;
      th_r   <= psi49;
      res_end_r  <= end_hit;
      res_over_r <= end_hit ? $signed({1'b0, arc_pos_r} - {1'b0, arc_length_r}) : '0;
      res_px_r   <= '0;
      res_py_r   <= '0;
      if (end_hit)                res_path_r <= '0;
      else if (path_w > 33'sh07FFFFFFF)  res_path_r <= 32'sh7FFFFFFF;
      else if (path_w < -33'sh080000000) res_path_r <= 32'sh80000000;
      else                        res_path_r <= path_w[31:0];
    end

    // serial divide of position by radius, one quotient bit per cycle
    if (state_r == S_DIV) begin
      if (launch_r) begin
        rem_r <= '0;
        quo_r <= {arc_pos_r, 16'd0};
        cnt_r <= 6'(DIV_STEPS);
      end else begin
        rem_r <= dge ? 31'(dtrial - {1'b0, dvs}) : dtrial[30:0];
        quo_r <= {quo_r[45:0], dge};
        cnt_r <= cnt_r - 1'b1;
      end
    end

    // point angle
    if (state_r == S_TH) begin
      th_r <= sg_neg ? psi49 - 49'(HALF_PI_Q16) - q49
                     : psi49 - 49'(HALF_PI_Q16) + q49;
    end

    // serial reduction modulo two pi, one angle bit per cycle
    if (state_r == S_MOD) begin
      if (launch_r) begin
        mag_r  <= th_r[48] ? 48'(-th_r) : th_r[47:0];
        mneg_r <= th_r[48];
        mrem_r <= '0;
        cnt_r  <= 6'(MOD_STEPS);
      end else begin
        mrem_r <= mge ? 19'(mtrial - 20'(TWO_PI_Q16)) : mtrial[18:0];
        mag_r  <= {mag_r[46:0], 1'b0};
        cnt_r  <= cnt_r - 1'b1;
      end
    end

    if (state_r == S_FOLD) begin
      ang_t_r   <= t2[ANG_W-1:0];
      ang_neg_r <= fneg;
    end

    // point coordinates
    if (mul_st.done && state_r == S_PX) res_px_r <= 32'(sat_coord(px_w));
    if (mul_st.done && state_r == S_PY) res_py_r <= 32'(sat_coord(py_w));

    if (state_r == S_OUT && out_go) begin
      out_path_r <= res_path_r;
      out_px_r   <= res_px_r;
      out_py_r   <= res_py_r;
      out_end_r  <= res_end_r;
      out_over_r <= res_over_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.path_pos  = out_path_r;
  assign out_ch.point_x   = out_px_r;
  assign out_ch.point_y   = out_py_r;
  assign out_ch.at_end    = out_end_r;
  assign out_ch.overshoot = out_over_r;

  // ---------------------------------------------------------------- checks
  a_idle_units: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !mul_st.busy && !cor_st.busy)
    else $error("unit busy while idle");

  a_cordic_done: assert property (@(posedge clk) disable iff (!rst_n)
    cor_st.done |-> state_r == S_CORDIC)
    else $error("CORDIC result outside its step");

  a_mul_done: assert property (@(posedge clk) disable iff (!rst_n)
    mul_st.done |-> (state_r == S_LEN || state_r == S_OFF || state_r == S_CX ||
                     state_r == S_CY || state_r == S_PX || state_r == S_PY))
    else $error("multiplier result outside a multiply step");

  a_mod_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FOLD |-> $signed({2'b0, mrem_r}) < TWO_PI_Q16)
    else $error("angle remainder out of range");

endmodule
